### sv/cse_pkg.sv
// Shared types, constants and register codes for the CAN signal extract and scale block.
package cse_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  localparam int unsigned RAW_W      = 64;
  localparam int unsigned SCALED_W   = 64;
  localparam int unsigned BYTES_W    = 4;
  localparam int unsigned START_W    = 6;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned FACTOR_W   = 32;
  localparam int unsigned OFFSET_W   = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [START_W-1:0]         START_RST  = '0;
  localparam logic [LEN_W-1:0]           LEN_RST    = 7'd8;
  localparam logic                       ORDER_RST  = 1'b1;
  localparam logic                       SIGNED_RST = 1'b0;
  localparam logic signed [FACTOR_W-1:0] FACTOR_RST = 32'sd65536;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_POSITION = 3'd0,
    REG_FIELD_LENGTH   = 3'd1,
    REG_ORDER_SELECT   = 3'd2,
    REG_SIGNED_MODE    = 3'd3,
    REG_SCALE_FACTOR   = 3'd4,
    REG_SCALE_OFFSET   = 3'd5
  } cse_reg_e;

  // Field walk settings used by the front end.
  typedef struct packed {
    logic [START_W-1:0] start_position;
    logic [LEN_W-1:0]   field_length;
    logic               order_select;
    logic               signed_mode;
  } cse_field_cfg_t;

  // Scaling settings used by the back end.
  typedef struct packed {
    logic signed [FACTOR_W-1:0] scale_factor;
    logic signed [OFFSET_W-1:0] scale_offset;
  } cse_scale_cfg_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [RAW_W-1:0]        raw_bits;
    logic signed [RAW_W:0]   field_value;
    logic                    out_of_bounds;
  } cse_item_t;

endpackage

### sv/cse_front.sv
// Front end: walks the configured signal out of the payload and classifies it.
module cse_front #(
  parameter int unsigned PAYLOAD_BYTES = cse_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic [8*PAYLOAD_BYTES-1:0]     frame_data_i,
  input  logic [cse_pkg::BYTES_W-1:0]    frame_bytes_i,
  input  cse_pkg::cse_field_cfg_t        cfg_i,
  output cse_pkg::cse_item_t             item_o
);
  import cse_pkg::*;

  localparam logic [BYTES_W-1:0] MaxBytes = BYTES_W'(PAYLOAD_BYTES);

  logic [BYTES_W-1:0] nbytes;
  logic [7:0]         payload_bits;
  logic [RAW_W-1:0]   data;
  logic [RAW_W-1:0]   moto_data;
  logic [START_W-1:0] moto_first;
  logic [START_W-1:0] first;
  logic [7:0]         last_end;
  logic               len_bad;
  logic               oob;
  logic [RAW_W-1:0]   seg;
  logic [RAW_W-1:0]   seg_rev;
  logic [RAW_W-1:0]   len_mask;
  logic [RAW_W-1:0]   raw;
  logic [RAW_W-1:0]   raw_f;
  logic [LEN_W-1:0]   moto_shift;
  logic [START_W-1:0] msb_idx;
  logic               neg;

  assign nbytes       = (frame_bytes_i > MaxBytes) ? MaxBytes : frame_bytes_i;
  assign payload_bits = {1'b0, nbytes, 3'b000};
  assign data         = RAW_W'(frame_data_i);

  // Reverse bits inside each byte so the sawtooth walk becomes a straight run.
  always_comb begin
    for (int k = 0; k < RAW_W / 8; k++) begin
      for (int j = 0; j < 8; j++) begin
        moto_data[8*k + j] = data[8*k + 7 - j];
      end
    end
  end

  assign moto_first = {cfg_i.start_position[5:3], ~cfg_i.start_position[2:0]};
  assign first      = cfg_i.order_select ? cfg_i.start_position : moto_first;
  assign last_end   = {2'b00, first} + {1'b0, cfg_i.field_length};
  assign len_bad    = (cfg_i.field_length == '0)
                   || (cfg_i.field_length[6] && (cfg_i.field_length[5:0] != '0));
  assign oob        = len_bad || (last_end > payload_bits);

  assign seg      = (cfg_i.order_select ? data : moto_data) >> first;
  assign len_mask = ~({RAW_W{1'b1}} << cfg_i.field_length);

  always_comb begin
    for (int i = 0; i < RAW_W; i++) begin
      seg_rev[i] = seg[RAW_W - 1 - i];
    end
  end

  // First walked bit lands on the field MSB in Motorola order.
  assign moto_shift = 7'd64 - cfg_i.field_length;
  assign raw        = cfg_i.order_select ? (seg & len_mask) : (seg_rev >> moto_shift);
  assign raw_f      = oob ? '0 : raw;

  assign msb_idx = START_W'(cfg_i.field_length - 7'd1);
  assign neg     = cfg_i.signed_mode && !oob && raw_f[msb_idx];

  always_comb begin
    item_o.raw_bits      = raw_f;
    item_o.out_of_bounds = oob;
    item_o.field_value   = neg ? {1'b1, raw_f | ~len_mask} : {1'b0, raw_f};
  end

endmodule

### sv/cse_queue.sv
// Short item queue between the front end and the scaling back end.
module cse_queue #(
  parameter int unsigned DEPTH = cse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  cse_pkg::cse_item_t  push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output cse_pkg::cse_item_t  pop_item_o
);
  import cse_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  cse_item_t       slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

### sv/cse_back.sv
// Back end: multiplies by the factor in two halves, adds the offset, saturates.
module cse_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   item_valid_i,
  output logic                                   item_ready_o,
  input  cse_pkg::cse_item_t                     item_i,
  input  cse_pkg::cse_scale_cfg_t                cfg_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [cse_pkg::RAW_W-1:0]              raw_bits_o,
  output logic signed [cse_pkg::SCALED_W-1:0]    scaled_value_o,
  output logic                                   out_of_bounds_o,
  output logic                                   saturated_o
);
  import cse_pkg::*;

  localparam logic signed [SCALED_W-1:0] MaxVal = {1'b0, {(SCALED_W-1){1'b1}}};
  localparam logic signed [SCALED_W-1:0] MinVal = {1'b1, {(SCALED_W-1){1'b0}}};

  // Stage 1: partial products.
  logic                     v1_q;
  logic signed [64:0]       plo_q, phi_q;
  logic [RAW_W-1:0]         raw1_q;
  logic                     oob1_q;
  // Stage 2: full product.
  logic                     v2_q;
  logic signed [96:0]       prod_q;
  logic [RAW_W-1:0]         raw2_q;
  logic                     oob2_q;
  // Output register.
  logic                     vo_q;
  logic signed [SCALED_W-1:0] res_q;
  logic [RAW_W-1:0]         rawo_q;
  logic                     oobo_q;
  logic                     sato_q;

  logic                     en1, en2, eno;
  logic signed [32:0]       lo_s, hi_s;
  logic signed [64:0]       plo_d, phi_d;
  logic signed [96:0]       prod_d;
  logic signed [97:0]       sum_d;
  logic [34:0]              sum_top;
  logic                     sat_d;
  logic signed [SCALED_W-1:0] res_d;

  assign eno          = !vo_q || out_ready_i;
  assign en2          = !v2_q || eno;
  assign en1          = !v1_q || en2;
  assign item_ready_o = en1;

  assign lo_s  = $signed({1'b0, item_i.field_value[31:0]});
  assign hi_s  = item_i.field_value[64:32];
  assign plo_d = 65'(lo_s) * 65'(cfg_i.scale_factor);
  assign phi_d = 65'(hi_s) * 65'(cfg_i.scale_factor);

  assign prod_d = $signed({phi_q, 32'h0}) + $signed({{32{plo_q[64]}}, plo_q});

  assign sum_d   = $signed({prod_q[96], prod_q})
                 + $signed({{50{cfg_i.scale_offset[47]}}, cfg_i.scale_offset});
  assign sum_top = sum_d[97:63];
  assign sat_d   = !((sum_top == '0) || (sum_top == '1));
  assign res_d   = sat_d ? (sum_d[97] ? MinVal : MaxVal) : sum_d[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= item_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (eno) begin
        vo_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && item_valid_i) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      raw1_q <= item_i.raw_bits;
      oob1_q <= item_i.out_of_bounds;
    end
    if (en2 && v1_q) begin
      prod_q <= prod_d;
      raw2_q <= raw1_q;
      oob2_q <= oob1_q;
    end
    if (eno && v2_q) begin
      res_q  <= res_d;
      rawo_q <= raw2_q;
      oobo_q <= oob2_q;
      sato_q <= sat_d;
    end
  end

  assign out_valid_o     = vo_q;
  assign raw_bits_o      = rawo_q;
  assign scaled_value_o  = res_q;
  assign out_of_bounds_o = oobo_q;
  assign saturated_o     = sato_q;

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_bounds_o) |-> raw_bits_o == '0)
    else $error("out of bounds item carries raw bits");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (scaled_value_o == MaxVal || scaled_value_o == MinVal))
    else $error("saturated item not at a limit");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && vo_q && !out_ready_i) |=> v2_q && $stable(prod_q))
    else $error("product stage lost an item under stall");

endmodule

### sv/can_signal_extract_scale.sv
// Top level of the CAN signal extract and scale block.
//
// Input channel (in_valid_i/in_ready_o) takes one CAN payload per item:
// frame_data_i holds byte k at bits 8k..8k+7, frame_bytes_i its byte count
// (values above PAYLOAD_BYTES count as PAYLOAD_BYTES). Output channel
// (out_valid_o/out_ready_i) returns one result item per input item, in order:
// the raw field, raw*factor+offset in Q48.16 with saturation, and flags.
// Configuration writes (cfg_valid_i, always ready) select register
// cfg_index_i; unknown indexes are dropped. Write only while idle.
// An accepted item passes through the queue, the partial product stage,
// the product stage and the offset/saturate output register.
// Throughput: one item per cycle while the receiver does not stall; the 65x32
// product is split into two 33x32 multipliers and summed in the next stage.
// Reset clears the queue and pipeline valids and loads register defaults
// (start 0, length 8, Intel order, unsigned, factor 1.0, offset 0).
// When the receiver stalls, the pipeline fills, then the two-entry queue,
// and only then in_ready_o drops.
module can_signal_extract_scale #(
  parameter int unsigned PAYLOAD_BYTES = cse_pkg::PAYLOAD_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH   = cse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [8*PAYLOAD_BYTES-1:0]           frame_data_i,
  input  logic [cse_pkg::BYTES_W-1:0]          frame_bytes_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cse_pkg::RAW_W-1:0]            raw_bits_o,
  output logic signed [cse_pkg::SCALED_W-1:0]  scaled_value_o,
  output logic                                 out_of_bounds_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cse_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cse_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import cse_pkg::*;

  cse_field_cfg_t field_cfg_q;
  cse_scale_cfg_t scale_cfg_q;
  cse_item_t      front_item;
  cse_item_t      back_item;
  logic           back_valid;
  logic           back_ready;
  logic           cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_cfg_q.start_position <= START_RST;
      field_cfg_q.field_length   <= LEN_RST;
      field_cfg_q.order_select   <= ORDER_RST;
      field_cfg_q.signed_mode    <= SIGNED_RST;
      scale_cfg_q.scale_factor   <= FACTOR_RST;
      scale_cfg_q.scale_offset   <= OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_START_POSITION: field_cfg_q.start_position <= cfg_data_i[START_W-1:0];
        REG_FIELD_LENGTH:   field_cfg_q.field_length   <= cfg_data_i[LEN_W-1:0];
        REG_ORDER_SELECT:   field_cfg_q.order_select   <= cfg_data_i[0];
        REG_SIGNED_MODE:    field_cfg_q.signed_mode    <= cfg_data_i[0];
        REG_SCALE_FACTOR:   scale_cfg_q.scale_factor   <= cfg_data_i[FACTOR_W-1:0];
        REG_SCALE_OFFSET:   scale_cfg_q.scale_offset   <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  cse_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .frame_data_i  (frame_data_i),
    .frame_bytes_i (frame_bytes_i),
    .cfg_i         (field_cfg_q),
    .item_o        (front_item)
  );

  cse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  cse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (back_valid),
    .item_ready_o    (back_ready),
    .item_i          (back_item),
    .cfg_i           (scale_cfg_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .raw_bits_o      (raw_bits_o),
    .scaled_value_o  (scaled_value_o),
    .out_of_bounds_o (out_of_bounds_o),
    .saturated_o     (saturated_o)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the CAN signal extract and scale block.
module testbench;
  import cse_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned RANDOM_PHASES = 38;
  localparam int unsigned PHASE_ITEMS   = 40;

  // Indexes outside the register map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0]    raw_bits;
    logic [SCALED_W-1:0] scaled_value;
    logic                out_of_bounds;
    logic                saturated;
  } sig_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [63:0] frame_data;
  logic [BYTES_W-1:0] frame_bytes;
  logic out_valid;
  logic out_ready;
  logic [RAW_W-1:0] raw_bits;
  logic signed [SCALED_W-1:0] scaled_value;
  logic oob_flag;
  logic sat_flag;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the register file.
  logic [START_W-1:0]         sh_start;
  logic [LEN_W-1:0]           sh_len;
  logic                       sh_intel;
  logic                       sh_signed;
  logic signed [FACTOR_W-1:0] sh_factor;
  logic signed [OFFSET_W-1:0] sh_offset;

  // Newest item at the front, oldest at the back.
  sig_result_t expected_q[$];
  int unsigned err_count;
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  logic hold_tog;

  can_signal_extract_scale dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .frame_data_i   (frame_data),
    .frame_bytes_i  (frame_bytes),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .raw_bits_o     (raw_bits),
    .scaled_value_o (scaled_value),
    .out_of_bounds_o(oob_flag),
    .saturated_o    (sat_flag),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk = ~clk;

  // Walk the signal bits out of the payload, then scale with 128-bit headroom.
  function automatic sig_result_t predict_result(logic [63:0] data, logic [BYTES_W-1:0] nbytes);
    sig_result_t r;
    int unsigned limit;
    int unsigned pos;
    int unsigned len;
    int unsigned k;
    logic ok;
    logic signed [127:0] wide;
    logic signed [127:0] fac;
    logic signed [127:0] off;
    logic signed [127:0] sum;
    r = '0;
    limit = ((nbytes > 8) ? 8 : nbytes) * 8;
    len = 32'(sh_len);
    pos = 32'(sh_start);
    ok = (len != 0) && (len <= 64);
    for (k = 0; ok && k < len; k++) begin
      if (pos >= limit) begin
        ok = 1'b0;
      end else begin
        r.raw_bits[sh_intel ? k : len - 1 - k] = data[pos];
        if (sh_intel) pos++;
        else if (pos % 8 == 0) pos += 15;
        else pos--;
      end
    end
    if (!ok) begin
      r.raw_bits = '0;
      r.out_of_bounds = 1'b1;
    end
    wide = {64'b0, r.raw_bits};
    if (!r.out_of_bounds && sh_signed && r.raw_bits[len-1]) begin
      for (k = len; k < 128; k++) wide[k] = 1'b1;
    end
    fac = {{96{sh_factor[FACTOR_W-1]}}, sh_factor};
    off = {{80{sh_offset[OFFSET_W-1]}}, sh_offset};
    sum = wide * fac + off;
    if (sum[127:63] == '0 || sum[127:63] == '1) begin
      r.scaled_value = sum[63:0];
    end else begin
      r.saturated = 1'b1;
      r.scaled_value = sum[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    err_count++;
    $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
  endtask

  task automatic send_frame(input logic [63:0] data, input logic [BYTES_W-1:0] nbytes);
    in_valid <= 1'b1;
    frame_data <= data;
    frame_bytes <= nbytes;
    do @(posedge clk); while (!in_ready);
    expected_q.push_front(predict_result(data, nbytes));
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid, wait out every outstanding item and let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the block empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_START_POSITION: sh_start = val[START_W-1:0];
      REG_FIELD_LENGTH:   sh_len = val[LEN_W-1:0];
      REG_ORDER_SELECT:   sh_intel = val[0];
      REG_SIGNED_MODE:    sh_signed = val[0];
      REG_SCALE_FACTOR:   sh_factor = val[FACTOR_W-1:0];
      REG_SCALE_OFFSET:   sh_offset = val[OFFSET_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // New setting for every register; bias the length so most fields fit.
  task automatic pick_random_setup();
    logic [START_W-1:0] s;
    logic intel;
    int unsigned span;
    logic [LEN_W-1:0] len;
    logic [31:0] fac;
    logic [47:0] off;
    logic [47:0] junk;
    settle();
    s = START_W'($urandom_range(0, 63));
    intel = 1'($urandom_range(0, 1));
    span = intel ? 64 - s : (s % 8) + 1 + 8 * (7 - s / 8);
    case ($urandom_range(0, 9))
      0: len = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
      1: len = 7'($urandom_range(1, 64));
      2: len = 7'(span);
      default: len = 7'($urandom_range(1, span));
    endcase
    case ($urandom_range(0, 5))
      0: fac = 32'h8000_0000;
      1: fac = 32'h7FFF_FFFF;
      2: fac = 32'h0001_0000;
      3: fac = $urandom_range(0, 15);
      default: fac = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: off = 48'h8000_0000_0000;
      1: off = 48'h7FFF_FFFF_FFFF;
      2: off = '0;
      default: off = 48'({$urandom, $urandom});
    endcase
    // Upper bits beyond each register's width must be ignored.
    junk = 48'({$urandom, $urandom});
    write_reg(REG_START_POSITION, {junk[47:6], s});
    write_reg(REG_FIELD_LENGTH, {junk[40:0], len});
    write_reg(REG_ORDER_SELECT, {junk[46:0], intel});
    write_reg(REG_SIGNED_MODE, {junk[47:1], 1'($urandom_range(0, 1))});
    write_reg(REG_SCALE_FACTOR, {junk[15:0], fac});
    write_reg(REG_SCALE_OFFSET, off);
  endtask

  task automatic send_random_frame();
    logic [BYTES_W-1:0] nbytes;
    nbytes = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
    send_frame({$urandom, $urandom}, nbytes);
  endtask

  task automatic test_reset_defaults();
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_frame(64'h0123_4567_89AB_CDEF, 4'd0);
    send_frame(64'hDEAD_BEEF_CAFE_F00D, 4'd15);
    send_frame(64'hFFFF_FFFF_FFFF_FF5A, 4'd1);
  endtask

  task automatic test_length_limits();
    settle();
    write_reg(REG_SCALE_OFFSET, 48'h7FFF_FFFF_FFFF);
    write_reg(REG_FIELD_LENGTH, 48'd0);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    write_reg(REG_FIELD_LENGTH, 48'd65);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    write_reg(REG_FIELD_LENGTH, 48'd127);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    write_reg(REG_FIELD_LENGTH, 48'd64);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    write_reg(REG_START_POSITION, 48'd63);
    write_reg(REG_FIELD_LENGTH, 48'd1);
    send_frame(64'h8000_0000_0000_0000, 4'd8);
    write_reg(REG_FIELD_LENGTH, 48'd2);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    write_reg(REG_START_POSITION, 48'd4);
    write_reg(REG_FIELD_LENGTH, 48'd12);
    send_frame(64'hFFFF_FFFF_FF00_A5C3, 4'd2);
  endtask

  task automatic test_scaling_extremes();
    settle();
    write_reg(REG_START_POSITION, 48'd0);
    write_reg(REG_FIELD_LENGTH, 48'd64);
    write_reg(REG_SIGNED_MODE, 48'd1);
    write_reg(REG_SCALE_FACTOR, 48'h7FFF_FFFF);
    write_reg(REG_SCALE_OFFSET, 48'd0);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_frame(64'h8000_0000_0000_0000, 4'd8);
    write_reg(REG_SCALE_FACTOR, 48'h8000_0000);
    send_frame(64'h8000_0000_0000_0000, 4'd8);
    send_frame(64'h0000_0000_0000_0001, 4'd8);
    write_reg(REG_SIGNED_MODE, 48'd0);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    write_reg(REG_SCALE_FACTOR, 48'd0);
    write_reg(REG_SCALE_OFFSET, 48'h8000_0000_0000);
    send_frame(64'h7E3C_A5F0_1234_8888, 4'd8);
    write_reg(REG_FIELD_LENGTH, 48'd8);
    write_reg(REG_SCALE_FACTOR, 48'd1);
    write_reg(REG_SCALE_OFFSET, 48'hFFFF_FFFF_FFFF);
    send_frame(64'h0, 4'd8);
  endtask

  task automatic test_motorola_walk();
    settle();
    write_reg(REG_ORDER_SELECT, 48'd0);
    write_reg(REG_START_POSITION, 48'd7);
    write_reg(REG_FIELD_LENGTH, 48'd64);
    write_reg(REG_SCALE_FACTOR, 48'h1_0000);
    write_reg(REG_SCALE_OFFSET, 48'd0);
    send_frame(64'h0123_4567_89AB_CDEF, 4'd8);
    send_frame(64'h0123_4567_89AB_CDEF, 4'd7);
    write_reg(REG_START_POSITION, 48'd60);
    write_reg(REG_FIELD_LENGTH, 48'd5);
    send_frame(64'h1700_0000_0000_0000, 4'd8);
    write_reg(REG_FIELD_LENGTH, 48'd6);
    send_frame(64'h1700_0000_0000_0000, 4'd8);
    write_reg(REG_START_POSITION, 48'd0);
    write_reg(REG_FIELD_LENGTH, 48'd9);
    send_frame(64'h0000_0000_0000_B301, 4'd2);
    write_reg(REG_START_POSITION, 48'd55);
    write_reg(REG_FIELD_LENGTH, 48'd3);
    write_reg(REG_SIGNED_MODE, 48'd1);
    send_frame(64'h00A0_0000_0000_0000, 4'd8);
  endtask

  task automatic test_register_decode();
    settle();
    write_reg(REG_UNMAPPED_LO, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_UNMAPPED_HI, 48'h0000_0000_0000);
    send_frame(64'h00C0_0000_0000_0000, 4'd8);
  endtask

  // Stall the receiver long enough to back up the pipeline into the input.
  task automatic test_backpressure();
    pick_random_setup();
    tx_gap_pct = 0;
    rx_stall_pct <= 0;
    hold_tog <= ~hold_tog;
    repeat (24) send_random_frame();
    settle();
    repeat (8) send_random_frame();
  endtask

  task automatic test_random_frames();
    int unsigned phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_random_setup();
      case ($urandom_range(0, 3))
        0: tx_gap_pct = 0;
        1: tx_gap_pct = 15;
        2: tx_gap_pct = 35;
        default: tx_gap_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0: rx_stall_pct <= 0;
        1: rx_stall_pct <= 15;
        2: rx_stall_pct <= 35;
        default: rx_stall_pct <= 60;
      endcase
      repeat (PHASE_ITEMS) send_random_frame();
    end
  endtask

  task automatic test_streaming_tail();
    tx_gap_pct = 0;
    rx_stall_pct <= 0;
    pick_random_setup();
    repeat (60) send_random_frame();
  endtask

  initial begin : main_seq
    rst_n = 1'b0;
    in_valid = 1'b0;
    frame_data = '0;
    frame_bytes = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    hold_tog = 1'b0;
    sh_start = START_RST;
    sh_len = LEN_RST;
    sh_intel = ORDER_RST;
    sh_signed = SIGNED_RST;
    sh_factor = FACTOR_RST;
    sh_offset = OFFSET_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_length_limits();
    test_scaling_extremes();
    test_motorola_walk();
    test_register_decode();
    test_backpressure();
    test_random_frames();
    test_streaming_tail();
    settle();
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : rx_side
    int unsigned stall_left;
    logic hold_seen;
    stall_left = 0;
    hold_seen = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    sig_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected item raw_bits", 64'h0, raw_bits);
      end else begin
        want = expected_q.pop_back();
        if (raw_bits !== want.raw_bits)
          flag_mismatch("raw_bits", want.raw_bits, raw_bits);
        if (scaled_value !== want.scaled_value)
          flag_mismatch("scaled_value", want.scaled_value, scaled_value);
        if (oob_flag !== want.out_of_bounds)
          flag_mismatch("out_of_bounds", 64'(want.out_of_bounds), 64'(oob_flag));
        if (sat_flag !== want.saturated)
          flag_mismatch("saturated", 64'(want.saturated), 64'(sat_flag));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
